FILE: design/anpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anpu_pkg
// Shared types, widths, register indexes and helpers of the Adam/Nadam core.
// ----------------------------------------------------------------------------
package anpu_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int MOM2_W   = 31;
   localparam int BETA_W   = 17;
   localparam int EPS_W    = 16;
   localparam int MAG_W    = 48;
   localparam int HALF_W   = 24;
   localparam int NUMER_W  = 80;
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int SQREM_W  = 36;
   localparam int DEN_W    = 33;
   localparam int QUO_W    = 34;
   localparam int CSR_IDX_W = 3;

   localparam logic [BETA_W-1:0] ONE_Q = 17'h1_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LRATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS2 = 3'd6;

   typedef struct packed {
      logic              mode;
      logic [31:0]       step_size;
      logic [BETA_W-1:0] beta1;
      logic [BETA_W-1:0] beta2;
      logic [31:0]       bias1;
      logic [31:0]       bias2;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] m1;
      logic [MOM2_W-1:0]        v1;
      logic signed [DATA_W-1:0] w;
      logic                     sat;
      logic                     neg;
      logic [NUMER_W-1:0]       numer;
   } carry_type;

   // {clipped flag, value} of a signed value forced into 32 bits
   function automatic logic [DATA_W:0] clip_s32(input logic signed [63:0] x);
      logic [DATA_W:0] r;
      if (x > 64'sd2147483647) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (x < -64'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, x[DATA_W-1:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/anpu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anpu_front
// Eight-stage moment update: new moments, numerator, bias correction and
// the product of the step magnitude with the learning rate.
// ----------------------------------------------------------------------------
module anpu_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire anpu_pkg::cfg_type           cfg,
   input  wire                              in_valid,
   input  wire logic signed [31:0]          in_g,
   input  wire logic signed [31:0]          in_m,
   input  wire logic [30:0]                 in_v,
   input  wire logic signed [31:0]          in_w,
   output logic                             out_valid,
   output anpu_pkg::carry_type              out_carry,
   output logic [anpu_pkg::RAD_W-1:0]       out_rad
);

   logic [7:0] vld_ff;

   logic [16:0] omb1, omb2;
   logic [31:0] ag;

   // stage 1
   logic signed [49:0] pa1_in, pa1_ff, pb1_in, pb1_ff;
   logic [63:0] gg1_in, gg1_ff;
   logic [47:0] pv1_in, pv1_ff;
   logic signed [31:0] g1_ff, w1_ff;
   // stage 2
   logic signed [63:0] msum;
   logic [32:0] m1clip;
   logic [63:0] pv2_in, pv2_ff;
   logic [47:0] pv1_2_ff;
   logic signed [31:0] m1_2_ff, g2_ff, w2_ff;
   logic sat2_ff;
   // stage 3
   logic [63:0] vsum;
   logic [47:0] vsh;
   logic [30:0] v1_in, v1_3_ff;
   logic vsat;
   logic signed [49:0] na_in, na3_ff, nb_in, nb3_ff;
   logic signed [31:0] m1_3_ff, w3_ff;
   logic sat3_ff;
   // stage 4
   logic signed [63:0] nsum;
   logic [32:0] nclip;
   logic signed [31:0] num_in, num4_ff, m1_4_ff, w4_ff;
   logic [62:0] pvh_in, pvh4_ff;
   logic [30:0] v1_4_ff;
   logic sat4_in, sat4_ff;
   // stage 5
   logic signed [63:0] pmh_in, pmh5_ff;
   logic [63:0] rad5_in, rad5_ff;
   logic signed [31:0] m1_5_ff, w5_ff;
   logic [30:0] v1_5_ff;
   logic sat5_ff;
   // stage 6
   logic signed [47:0] mh;
   logic [47:0] amag_in, amag6_ff;
   logic [63:0] rad6_ff;
   logic signed [31:0] m1_6_ff, w6_ff;
   logic [30:0] v1_6_ff;
   logic sat6_ff, neg6_ff;
   // stage 7
   logic [55:0] plo_in, plo7_ff, phi_in, phi7_ff;
   logic [63:0] rad7_ff;
   logic signed [31:0] m1_7_ff, w7_ff;
   logic [30:0] v1_7_ff;
   logic sat7_ff, neg7_ff;
   // stage 8
   anpu_pkg::carry_type car_in, car8_ff;
   logic [63:0] rad8_ff;

   always_comb begin
      omb1 = anpu_pkg::ONE_Q - cfg.beta1;
      omb2 = anpu_pkg::ONE_Q - cfg.beta2;
      ag = in_g[31] ? 32'(-in_g) : 32'(in_g);
      pa1_in = 50'(in_m) * $signed(50'(cfg.beta1));
      pb1_in = 50'(in_g) * $signed(50'(omb1));
      gg1_in = 64'(ag) * 64'(ag);
      pv1_in = 48'(cfg.beta2) * 48'(in_v);

      msum = 64'(pa1_ff) + 64'(pb1_ff);
      m1clip = anpu_pkg::clip_s32(msum >>> anpu_pkg::FRAC_W);
      pv2_in = 64'(omb2) * 64'(gg1_ff[63:16]);

      vsum = 64'(pv1_2_ff) + pv2_ff;
      vsh = vsum[63:16];
      vsat = vsh > 48'h7fff_ffff;
      v1_in = vsat ? 31'h7fff_ffff : vsh[30:0];
      na_in = 50'(m1_2_ff) * $signed(50'(cfg.beta1));
      nb_in = 50'(g2_ff) * $signed(50'(omb1));

      nsum = 64'(na3_ff) + 64'(nb3_ff);
      nclip = anpu_pkg::clip_s32(nsum >>> anpu_pkg::FRAC_W);
      num_in = cfg.mode ? $signed(nclip[31:0]) : m1_3_ff;
      sat4_in = sat3_ff | (cfg.mode & nclip[32]);
      pvh_in = 63'(v1_3_ff) * 63'(cfg.bias2);

      pmh_in = 64'(num4_ff) * $signed(64'(cfg.bias1));
      // only the corrected second moment reaches the root, at the same scale
      rad5_in = {1'b0, pvh4_ff[62:16], 16'h0000};

      mh = pmh5_ff[63:16];
      amag_in = mh[47] ? 48'(-mh) : 48'(mh);

      plo_in = 56'(amag6_ff[23:0]) * 56'(cfg.step_size);
      phi_in = 56'(amag6_ff[47:24]) * 56'(cfg.step_size);

      car_in.m1 = m1_7_ff;
      car_in.v1 = v1_7_ff;
      car_in.w = w7_ff;
      car_in.sat = sat7_ff;
      car_in.neg = neg7_ff;
      car_in.numer = (80'(phi7_ff) << anpu_pkg::HALF_W) + 80'(plo7_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa1_ff <= pa1_in; pb1_ff <= pb1_in; gg1_ff <= gg1_in; pv1_ff <= pv1_in;
         g1_ff <= in_g; w1_ff <= in_w;

         m1_2_ff <= $signed(m1clip[31:0]); sat2_ff <= m1clip[32];
         pv1_2_ff <= pv1_ff; pv2_ff <= pv2_in; g2_ff <= g1_ff; w2_ff <= w1_ff;

         v1_3_ff <= v1_in; sat3_ff <= sat2_ff | vsat;
         na3_ff <= na_in; nb3_ff <= nb_in; m1_3_ff <= m1_2_ff; w3_ff <= w2_ff;

         num4_ff <= num_in; sat4_ff <= sat4_in; pvh4_ff <= pvh_in;
         m1_4_ff <= m1_3_ff; v1_4_ff <= v1_3_ff; w4_ff <= w3_ff;

         pmh5_ff <= pmh_in; rad5_ff <= rad5_in;
         m1_5_ff <= m1_4_ff; v1_5_ff <= v1_4_ff; w5_ff <= w4_ff; sat5_ff <= sat4_ff;

         amag6_ff <= amag_in; neg6_ff <= mh[47]; rad6_ff <= rad5_ff;
         m1_6_ff <= m1_5_ff; v1_6_ff <= v1_5_ff; w6_ff <= w5_ff; sat6_ff <= sat5_ff;

         plo7_ff <= plo_in; phi7_ff <= phi_in; neg7_ff <= neg6_ff; rad7_ff <= rad6_ff;
         m1_7_ff <= m1_6_ff; v1_7_ff <= v1_6_ff; w7_ff <= w6_ff; sat7_ff <= sat6_ff;

         car8_ff <= car_in; rad8_ff <= rad7_ff;
      end
   end

   assign out_valid = vld_ff[7];
   assign out_carry = car8_ff;
   assign out_rad = rad8_ff;

endmodule
`default_nettype wire

FILE: design/anpu_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anpu_sqrt
// Pipelined integer square root, one root bit per stage over 32 stages.
// ----------------------------------------------------------------------------
module anpu_sqrt (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire                              in_valid,
   input  wire logic [anpu_pkg::RAD_W-1:0]  in_rad,
   input  wire anpu_pkg::carry_type         in_carry,
   output logic                             out_valid,
   output logic [anpu_pkg::ROOT_W-1:0]      out_root,
   output anpu_pkg::carry_type              out_carry
);

   localparam int STAGES = anpu_pkg::ROOT_W;

   logic                              vld_ff  [STAGES];
   logic [anpu_pkg::SQREM_W-1:0]      rem_ff  [STAGES];
   logic [anpu_pkg::ROOT_W-1:0]       root_ff [STAGES];
   logic [anpu_pkg::RAD_W-1:0]        rad_ff  [STAGES];
   anpu_pkg::carry_type               car_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                         vld_i;
      logic [anpu_pkg::SQREM_W-1:0] rem_i, remsh, trial;
      logic [anpu_pkg::ROOT_W-1:0]  root_i;
      logic [anpu_pkg::RAD_W-1:0]   rad_i;
      anpu_pkg::carry_type          car_i;
      logic                         ge;

      if (k == 0) begin : g_first
         assign vld_i = in_valid;
         assign rem_i = '0;
         assign root_i = '0;
         assign rad_i = in_rad;
         assign car_i = in_carry;
      end else begin : g_next
         assign vld_i = vld_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign rad_i = rad_ff[k-1];
         assign car_i = car_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign remsh = {rem_i[anpu_pkg::SQREM_W-3:0], rad_i[anpu_pkg::RAD_W-1 -: 2]};
      assign trial = {2'b00, root_i, 2'b01};
      assign ge = remsh >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= ge ? remsh - trial : remsh;
            root_ff[k] <= {root_i[anpu_pkg::ROOT_W-2:0], ge};
            rad_ff[k] <= {rad_i[anpu_pkg::RAD_W-3:0], 2'b00};
            car_ff[k] <= car_i;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_root = root_ff[STAGES-1];
   assign out_carry = car_ff[STAGES-1];

endmodule
`default_nettype wire

FILE: design/anpu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anpu_div
// Denominator stage with range check, then a restoring divider that makes
// one quotient bit per stage over 34 stages.
// ----------------------------------------------------------------------------
module anpu_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire logic [anpu_pkg::EPS_W-1:0]  epsilon,
   input  wire                              in_valid,
   input  wire logic [anpu_pkg::ROOT_W-1:0] in_root,
   input  wire anpu_pkg::carry_type         in_carry,
   output logic                             out_valid,
   output logic [anpu_pkg::QUO_W-1:0]       out_quo,
   output logic                             out_ovf,
   output logic                             out_dz,
   output anpu_pkg::carry_type              out_carry
);

   localparam int STAGES = anpu_pkg::QUO_W;

   logic [anpu_pkg::DEN_W-1:0] den_in, den0_ff;
   logic ovf_in, ovf0_ff, dz0_ff, vld0_ff;
   anpu_pkg::carry_type car0_ff;

   logic                        vld_ff [STAGES];
   logic [anpu_pkg::QUO_W-1:0]  rem_ff [STAGES];
   logic [anpu_pkg::QUO_W-1:0]  nlo_ff [STAGES];
   logic [anpu_pkg::QUO_W-1:0]  quo_ff [STAGES];
   logic [anpu_pkg::DEN_W-1:0]  den_ff [STAGES];
   logic                        ovf_ff [STAGES];
   logic                        dz_ff  [STAGES];
   anpu_pkg::carry_type         car_ff [STAGES];

   // quotient of 2^34 or more clips the weight anyway
   assign den_in = anpu_pkg::DEN_W'(in_root) + anpu_pkg::DEN_W'(epsilon);
   assign ovf_in = in_carry.numer >= (anpu_pkg::NUMER_W'(den_in) << anpu_pkg::QUO_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den0_ff <= den_in;
         ovf0_ff <= ovf_in;
         dz0_ff <= den_in == '0;
         car0_ff <= in_carry;
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                        vld_i, ovf_i, dz_i, ge;
      logic [anpu_pkg::QUO_W-1:0]  rem_i, nlo_i, quo_i;
      logic [anpu_pkg::DEN_W-1:0]  den_i;
      logic [anpu_pkg::QUO_W:0]    remsh, dext;
      anpu_pkg::carry_type         car_i;

      if (k == 0) begin : g_first
         assign vld_i = vld0_ff;
         assign rem_i = car0_ff.numer[2*anpu_pkg::QUO_W-1:anpu_pkg::QUO_W];
         assign nlo_i = car0_ff.numer[anpu_pkg::QUO_W-1:0];
         assign quo_i = '0;
         assign den_i = den0_ff;
         assign ovf_i = ovf0_ff;
         assign dz_i = dz0_ff;
         assign car_i = car0_ff;
      end else begin : g_next
         assign vld_i = vld_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign nlo_i = nlo_ff[k-1];
         assign quo_i = quo_ff[k-1];
         assign den_i = den_ff[k-1];
         assign ovf_i = ovf_ff[k-1];
         assign dz_i = dz_ff[k-1];
         assign car_i = car_ff[k-1];
      end

      assign remsh = {rem_i, nlo_i[anpu_pkg::QUO_W-1]};
      assign dext = (anpu_pkg::QUO_W+1)'(den_i);
      assign ge = remsh >= dext;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= ge ? anpu_pkg::QUO_W'(remsh - dext) : remsh[anpu_pkg::QUO_W-1:0];
            nlo_ff[k] <= {nlo_i[anpu_pkg::QUO_W-2:0], 1'b0};
            quo_ff[k] <= {quo_i[anpu_pkg::QUO_W-2:0], ge};
            den_ff[k] <= den_i;
            ovf_ff[k] <= ovf_i;
            dz_ff[k] <= dz_i;
            car_ff[k] <= car_i;
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quo = quo_ff[STAGES-1];
   assign out_ovf = ovf_ff[STAGES-1];
   assign out_dz = dz_ff[STAGES-1];
   assign out_carry = car_ff[STAGES-1];

endmodule
`default_nettype wire

FILE: design/adam_nadam_parameter_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adam_nadam_parameter_update_core
// Streaming Adam/Nadam update of one Q16.16 parameter element per word.
// ----------------------------------------------------------------------------
// The core takes one word per clock and returns one word per word taken, in
// order, through 8 stages of moment and product arithmetic, 32 stages of
// square root (one root bit each), a denominator stage and 34 stages of
// division (one quotient bit each), then the output register. The
// whole pipeline holds while a result waits, so throughput is one word per
// cycle whenever the result side takes words. Write registers only while no
// word is in flight.
module adam_nadam_parameter_update_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // gradient[31:0], first_moment[63:32], second_moment[94:64], weight[126:95]
   input  wire [127:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // new_first_moment[31:0], new_second_moment[62:32], new_weight[94:63]
   output logic [95:0]  rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire [2:0]    csr_index,
   input  wire [31:0]   csr_data
);

   logic        mode_ff;
   logic [31:0] lrate_ff, bias1_ff, bias2_ff;
   logic [16:0] beta1_ff, beta2_ff;
   logic [15:0] eps_ff;
   anpu_pkg::cfg_type cfg;

   logic advance;
   logic front_valid, sqrt_valid, div_valid, div_ovf, div_dz;
   anpu_pkg::carry_type front_carry, sqrt_carry, div_carry;
   logic [63:0] front_rad;
   logic [31:0] sqrt_root;
   logic [33:0] div_quo;

   logic [34:0] qmag;
   logic signed [63:0] wext, nw_sum;
   logic [32:0] nw_clip;
   logic signed [31:0] nw_in;
   logic sat_in;

   logic rsp_valid_ff, sat_ff;
   logic [95:0] data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         lrate_ff <= 32'd66;
         beta1_ff <= 17'd58982;
         beta2_ff <= 17'd65470;
         eps_ff <= 16'd1;
         bias1_ff <= 32'd65536;
         bias2_ff <= 32'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            anpu_pkg::CSR_MODE:  mode_ff <= csr_data[0];
            anpu_pkg::CSR_LRATE: lrate_ff <= csr_data;
            anpu_pkg::CSR_BETA1: beta1_ff <= csr_data[16:0];
            anpu_pkg::CSR_BETA2: beta2_ff <= csr_data[16:0];
            anpu_pkg::CSR_EPS:   eps_ff <= csr_data[15:0];
            anpu_pkg::CSR_BIAS1: bias1_ff <= csr_data;
            anpu_pkg::CSR_BIAS2: bias2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // decay above one acts as one
   always_comb begin
      cfg.mode = mode_ff;
      cfg.step_size = lrate_ff;
      cfg.beta1 = (beta1_ff > anpu_pkg::ONE_Q) ? anpu_pkg::ONE_Q : beta1_ff;
      cfg.beta2 = (beta2_ff > anpu_pkg::ONE_Q) ? anpu_pkg::ONE_Q : beta2_ff;
      cfg.bias1 = bias1_ff;
      cfg.bias2 = bias2_ff;
   end

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   anpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_g      ($signed(req_tdata[31:0])),
      .in_m      ($signed(req_tdata[63:32])),
      .in_v      (req_tdata[94:64]),
      .in_w      ($signed(req_tdata[126:95])),
      .out_valid (front_valid),
      .out_carry (front_carry),
      .out_rad   (front_rad)
   );

   anpu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_rad    (front_rad),
      .in_carry  (front_carry),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_carry (sqrt_carry)
   );

   anpu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .epsilon   (eps_ff),
      .in_valid  (sqrt_valid),
      .in_root   (sqrt_root),
      .in_carry  (sqrt_carry),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ovf   (div_ovf),
      .out_dz    (div_dz),
      .out_carry (div_carry)
   );

   always_comb begin
      qmag = div_ovf ? 35'h4_0000_0000 : {1'b0, div_quo};
      wext = 64'(div_carry.w);
      nw_sum = div_carry.neg ? wext - $signed(64'(qmag)) : wext + $signed(64'(qmag));
      nw_clip = anpu_pkg::clip_s32(nw_sum);
      if (div_dz) begin
         nw_in = div_carry.w;
         sat_in = 1'b1;
      end else begin
         nw_in = $signed(nw_clip[31:0]);
         sat_in = div_carry.sat | nw_clip[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= {1'b0, nw_in, div_carry.v1, div_carry.m1};
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tuser = sat_ff;

`ifndef ASSERT_OFF
   a_zero_den_flags: assert property (@(posedge clock) disable iff (reset)
      (div_valid && div_dz && advance) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("zero denominator did not flag the word");

   a_huge_step_clips: assert property (@(posedge clock) disable iff (reset)
      (div_valid && div_ovf && advance) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("oversized update did not clip the weight");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == anpu_pkg::CSR_MODE)
      |=> (mode_ff == $past(csr_data[0])))
      else $error("mode write lost");

   a_beta_clamp: assert property (@(posedge clock) disable iff (reset)
      (cfg.beta1 <= anpu_pkg::ONE_Q) && (cfg.beta2 <= anpu_pkg::ONE_Q)
      && ((beta1_ff <= anpu_pkg::ONE_Q) || (cfg.beta1 == anpu_pkg::ONE_Q)))
      else $error("decay factor above one reached the datapath");
`endif

endmodule
`default_nettype wire
